// ===== hw/rtl/lcc_pkg.sv =====
`default_nettype none

package lcc_pkg;

  // Operation codes carried by each input item.
  typedef enum logic [1:0] {
    OpTick    = 2'd0,
    OpReceive = 2'd1,
    OpReset   = 2'd2,
    OpFastFwd = 2'd3
  } lcc_op_e;

  typedef struct packed {
    lcc_op_e     op;
    logic [31:0] now_ms;
    logic [15:0] speed_permille;
    logic [31:0] time_value;
  } lcc_in_t;

  typedef struct packed {
    logic [31:0] local_time;
    logic [31:0] remote_time;
    logic [31:0] latency_estimate;
    logic        backwards_error;
  } lcc_out_t;

  // Widths of the tick scaling path.
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned ScaledW  = 16;
  localparam int unsigned ProdW    = ElapsedW + ScaledW;

  // Elapsed time is clamped to one second.
  localparam logic [ElapsedW-1:0] ClampMs = 10'd1000;

  // floor(p / 1000) = (p * RecipM) >> RecipK, exact for every p below 2^26.
  localparam int unsigned RecipK  = 36;
  localparam int unsigned RecipMW = 27;
  localparam logic [RecipMW-1:0] RecipM = 27'd68719477;

  // floor(x / 3) = (x * Div3M) >> 33 for every 32-bit x.
  localparam logic [31:0] Div3M = 32'hAAAA_AAAB;
  localparam int unsigned Div3K = 33;

  // Item after the scaling front end: the elapsed time is already scaled.
  typedef struct packed {
    lcc_op_e             op;
    logic [31:0]         time_value;
    logic [ScaledW-1:0]  scaled_ms;
  } lcc_scaled_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lcc_scale.sv =====
`default_nettype none

module lcc_scale import lcc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire lcc_in_t     in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output lcc_scaled_t      out_item_o
);

  // Stage one: input register.
  logic    s1_valid_q;
  lcc_in_t s1_item_q;

  // Stage two: elapsed time times speed.
  logic              s2_valid_q;
  lcc_op_e           s2_op_q;
  logic [31:0]       s2_time_q;
  logic [ProdW-1:0]  s2_prod_q;

  // Stage three: product divided by one thousand.
  logic        s3_valid_q;
  lcc_scaled_t s3_item_q;

  logic [31:0] last_tick_q;

  logic en1, en2, en3;
  logic [31:0]                elapsed_raw;
  logic [ElapsedW-1:0]        elapsed;
  logic [ProdW-1:0]           prod_d;
  logic [ProdW+RecipMW-1:0]   recip_prod;

  // Each stage moves on when it is empty or the one after it moves on.
  assign en3 = !s3_valid_q || !out_stall_i;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;
  assign in_stall_o = !en1;

  // Elapsed time since the last non-receive item, clamped to 0..1000 ms.
  assign elapsed_raw = s1_item_q.now_ms - last_tick_q;
  always_comb begin
    priority if (elapsed_raw[31]) begin
      elapsed = '0;
    end else if (elapsed_raw > {{(32-ElapsedW){1'b0}}, ClampMs}) begin
      elapsed = ClampMs;
    end else begin
      elapsed = elapsed_raw[ElapsedW-1:0];
    end
  end

  assign prod_d     = {{ScaledW{1'b0}}, elapsed} * {{ElapsedW{1'b0}}, s1_item_q.speed_permille};
  assign recip_prod = {{RecipMW{1'b0}}, s2_prod_q} * {{ProdW{1'b0}}, RecipM};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      last_tick_q <= '0;
    end else begin
      if (en1) begin
        s1_valid_q <= in_valid_i;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
        // Every operation but a receive restarts the tick reference.
        if (s1_valid_q && (s1_item_q.op != OpReceive)) begin
          last_tick_q <= s1_item_q.now_ms;
        end
      end
      if (en3) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (en2 && s1_valid_q) begin
      s2_op_q   <= s1_item_q.op;
      s2_time_q <= s1_item_q.time_value;
      s2_prod_q <= prod_d;
    end
    if (en3 && s2_valid_q) begin
      s3_item_q.op         <= s2_op_q;
      s3_item_q.time_value <= s2_time_q;
      s3_item_q.scaled_ms  <= recip_prod[RecipK+ScaledW-1:RecipK];
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_item_o  = s3_item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/latency_catchup_clock.sv =====
// Latency catch-up clock.
//
// Input channel: in_valid_i / in_stall_o / in_item_i carry one operation per
// item (tick, receive remote time, reset to time, fast-forward). Output
// channel: out_valid_o / out_stall_i / out_item_o return one result item per
// input item, in order, holding the clocks and the lag estimate after it.
//
// Throughput is one item per cycle while out_stall_i is low. An accepted item
// passes through one input register, one stage for the elapsed-time multiply,
// one for the divide by one thousand by reciprocal, and the state stage,
// which holds the clocks and the lag estimate and is also the output register.
// The tick reference lives in the multiply stage.
//
// Reset clears all clocks, the lag estimate and every valid bit. When the
// receiver stalls, the result is held; items already in flight keep moving
// into empty stages, and in_stall_o rises only once all stages are full.

`default_nettype none

module latency_catchup_clock import lcc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire lcc_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output lcc_out_t      out_item_o
);

  logic        sc_valid;
  logic        sc_stall;
  lcc_scaled_t sc_item;

  logic        out_valid_q;
  lcc_out_t    out_item_q;
  logic        adv;

  logic [31:0] local_q, local_d;
  logic [31:0] remote_q, remote_d;
  logic [31:0] lag_q, lag_d;
  logic        err_d;

  logic [31:0] d32;
  logic [31:0] d_times10;
  logic [31:0] behind;
  logic [31:0] catchup;
  logic [31:0] advance;
  logic [63:0] lag_div3_prod;
  logic [31:0] lag_div3;
  logic [31:0] recv_gap;
  logic [31:0] lag_avg_sum;

  lcc_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (sc_valid),
    .out_stall_i (sc_stall),
    .out_item_o  (sc_item)
  );

  // The state stage advances when its result register is free or being taken.
  assign adv      = !out_valid_q || !out_stall_i;
  assign sc_stall = !adv;

  // Terms for tick and receive.
  assign d32           = {{(32-ScaledW){1'b0}}, sc_item.scaled_ms};
  assign d_times10     = (d32 << 3) + (d32 << 1);
  assign behind        = remote_q - local_q;
  assign lag_div3_prod = {32'b0, lag_q} * {32'b0, Div3M};
  assign lag_div3      = {1'b0, lag_div3_prod[63:Div3K]};
  assign recv_gap      = remote_q - local_q;
  assign lag_avg_sum   = (lag_q << 3) - lag_q + recv_gap;

  // Next state for the operation in the state stage.
  always_comb begin
    local_d  = local_q;
    remote_d = remote_q;
    lag_d    = lag_q;
    err_d    = 1'b0;
    catchup  = '0;
    advance  = '0;
    unique case (sc_item.op)
      OpTick: begin
        priority if (lag_q > d_times10) begin
          catchup = lag_div3;
        end else if (lag_q > d32) begin
          catchup = d32 >> 3;
        end else begin
          catchup = '0;
        end
        if ($signed(d32 + catchup) > $signed(behind)) begin
          catchup = behind - d32;
        end
        advance = d32 + catchup;
        lag_d   = lag_q - catchup;
        if ($signed(advance) > $signed(behind)) begin
          advance = behind;
        end
        local_d = local_q + advance;
      end
      OpReceive: begin
        if (sc_item.time_value < remote_q) begin
          err_d = 1'b1;
        end else begin
          if (recv_gap < lag_q) begin
            lag_d = recv_gap;
          end else begin
            lag_d = lag_avg_sum >> 3;
          end
          remote_d = sc_item.time_value;
        end
      end
      OpReset: begin
        local_d  = sc_item.time_value;
        remote_d = sc_item.time_value;
        lag_d    = '0;
      end
      OpFastFwd: begin
        local_d = remote_q;
      end
      default: begin
        local_d = local_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      local_q     <= '0;
      remote_q    <= '0;
      lag_q       <= '0;
    end else if (adv) begin
      out_valid_q <= sc_valid;
      if (sc_valid) begin
        local_q  <= local_d;
        remote_q <= remote_d;
        lag_q    <= lag_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (adv && sc_valid) begin
      out_item_q.local_time       <= local_d;
      out_item_q.remote_time      <= remote_d;
      out_item_q.latency_estimate <= lag_d;
      out_item_q.backwards_error  <= err_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lcc_checker.sv =====
`default_nettype none

module lcc_checker import lcc_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire lcc_in_t  in_item_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire lcc_out_t out_item_o
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] inflight_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Items accepted whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + {2'b0, in_acc} - {2'b0, out_acc};
    end
  end

  // A result held by the receiver stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // The input side only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // Every result belongs to an accepted item.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result without an accepted item");

  // The pipeline holds at most four items.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more items in flight than stages");

  // A rejected receive leaves the remote time as it was.
  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc ##1 (out_valid_o && out_item_o.backwards_error && inflight_q == 3'd1)
      |-> out_item_o.remote_time == $past(out_item_o.remote_time))
    else $error("rejected receive changed the remote time");

endmodule

bind latency_catchup_clock lcc_checker u_lcc_checker (.*);

`default_nettype wire
